/* design/lba_chs_translator_core_defines.svh */
// Assertion macros for the LBA/CHS translator.
// Used by lba_chs_translator_core; needs clk and rst_n in scope.
`ifndef LBA_CHS_TRANSLATOR_CORE_DEFINES_SVH
`define LBA_CHS_TRANSLATOR_CORE_DEFINES_SVH

// same-cycle implication
`define LCT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define LCT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* design/lct_pkg.sv */
// Shared constants for the LBA/CHS translator.
// No dependencies.
package lct_pkg;

    localparam logic [1:0] CFG_HEADS   = 2'd0;
    localparam logic [1:0] CFG_SECTORS = 2'd1;
    localparam logic [1:0] CFG_CYLS    = 2'd2;
    localparam logic [1:0] CFG_TOTAL   = 2'd3;

    localparam logic [7:0]  HEADS_RST   = 8'd16;
    localparam logic [7:0]  SECTORS_RST = 8'd63;
    localparam logic [15:0] CYLS_RST    = 16'd1024;
    localparam logic [23:0] TOTAL_RST   = 24'd1032192;

    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 56;
    localparam int CFG_DATA_W = 24;

    localparam logic REQ_TO_CHS = 1'b0;
    localparam logic REQ_TO_LBA = 1'b1;

endpackage

/* design/lba_chs_translator_core.sv */
// LBA/CHS translator top level: config registers and the full translation pipeline.
// Depends on lct_pkg and lba_chs_translator_core_defines.svh.
//
// Takes one request word per cycle unless the output stalls; returns one result word
// per request, in order. The pipeline is an input register, then two restoring dividers
// (by sectors per track, then by heads) that each retire one quotient bit per stage.
// The CHS-to-LBA products ride in the first stages alongside. Stalls are absorbed
// stage by stage, so bubbles close up while the output waits.
module lba_chs_translator_core #(
    parameter int LBA_BITS = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // lba_in[23:0], xfer_count[31:24], cyl_in[47:32], head_in[55:48], sect_in[63:56]
    input  logic [lct_pkg::IN_DATA_W-1:0]   s_tdata,
    // req_type
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // lba_out[23:0], cyl_out[39:24], head_out[47:40], sect_out[55:48]
    output logic [lct_pkg::OUT_DATA_W-1:0]  m_tdata,
    // range_error
    output logic                            m_tuser,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [lct_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lct_pkg::*;

    localparam int NS = 2 * LBA_BITS + 1;
    localparam logic [31:0] LBA_MAX = 32'hFFFF_FFFF >> (32 - LBA_BITS);

    typedef struct packed {
        logic                req;
        logic [LBA_BITS-1:0] lba;
        logic [7:0]          cnt;
        logic [15:0]         cyl;
        logic [7:0]          head;
        logic [7:0]          sect;
        logic [LBA_BITS-1:0] num;
        logic [7:0]          rem1;
        logic [7:0]          rem2;
        logic [31:0]         prod;
        logic                err;
    } stage_t;

    logic [7:0]  heads_reg;
    logic [7:0]  sectors_reg;
    logic [15:0] cyls_reg;
    logic [23:0] total_reg;
    logic [7:0]  hpc_nz;
    logic [7:0]  spt_nz;

    stage_t        st_reg [NS];
    stage_t        st_next [NS];
    logic [NS-1:0] vld_reg;
    logic [NS:0]   adv;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heads_reg   <= HEADS_RST;
            sectors_reg <= SECTORS_RST;
            cyls_reg    <= CYLS_RST;
            total_reg   <= TOTAL_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_HEADS:   heads_reg   <= cfg_data[7:0];
                CFG_SECTORS: sectors_reg <= cfg_data[7:0];
                CFG_CYLS:    cyls_reg    <= cfg_data[15:0];
                CFG_TOTAL:   total_reg   <= cfg_data;
                default:     ;
            endcase
        end
    end

    assign hpc_nz = (heads_reg == 8'd0) ? 8'd1 : heads_reg;
    assign spt_nz = (sectors_reg == 8'd0) ? 8'd1 : sectors_reg;

    always_comb
    begin
        logic [31:0] lba_ext;
        logic [8:0]  t9;
        logic [7:0]  dv;
        logic        sat;
        stage_t      s;

        lba_ext = {8'd0, s_tdata[23:0]};
        s.req   = s_tuser;
        s.lba   = lba_ext[LBA_BITS-1:0];
        s.cnt   = s_tdata[31:24];
        s.cyl   = s_tdata[47:32];
        s.head  = s_tdata[55:48];
        s.sect  = s_tdata[63:56];
        s.num   = lba_ext[LBA_BITS-1:0];
        s.rem1  = 8'd0;
        s.rem2  = 8'd0;
        s.prod  = 32'd0;
        s.err   = 1'b0;
        st_next[0] = s;

        for (int k = 1; k < NS; k++)
        begin
            s = st_reg[k-1];
            if (k <= LBA_BITS)
            begin
                dv = spt_nz;
                t9 = {s.rem1, s.num[LBA_BITS-1]};
            end
            else
            begin
                dv = hpc_nz;
                t9 = {s.rem2, s.num[LBA_BITS-1]};
            end
            sat = (t9 >= {1'b0, dv});
            if (sat)
                t9 = t9 - {1'b0, dv};
            s.num = {s.num[LBA_BITS-2:0], sat};
            if (k <= LBA_BITS)
                s.rem1 = t9[7:0];
            else
                s.rem2 = t9[7:0];

            if (k == 1)
            begin
                s.prod = {16'd0, s.cyl} * {24'd0, hpc_nz} + {24'd0, s.head};
                if (s.req == REQ_TO_CHS)
                    s.err = ({1'b0, 32'(s.lba)} + 33'(s.cnt)) > 33'(total_reg);
            end
            else if (k == 2)
                s.prod = {8'd0, s.prod[23:0]} * {24'd0, spt_nz} + {24'd0, s.sect};
            else if (k == 3 && s.req == REQ_TO_LBA)
            begin
                sat   = (s.prod > LBA_MAX);
                s.err = sat || (s.cyl >= cyls_reg) || (s.head >= heads_reg) ||
                        (s.sect >= sectors_reg);
                if (sat)
                    s.prod = LBA_MAX;
            end
            st_next[k] = s;
        end
    end

    always_comb
    begin
        adv[NS] = m_tready;
        for (int k = NS - 1; k >= 0; k--)
            adv[k] = !vld_reg[k] || adv[k+1];
    end
    assign s_tready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (adv[0])
                vld_reg[0] <= s_tvalid;
            for (int k = 1; k < NS; k++)
            begin
                if (adv[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NS; k++)
        begin
            if (adv[k])
                st_reg[k] <= st_next[k];
        end
    end

    stage_t      o;
    logic [31:0] q_ext;
    logic [31:0] lba_o_ext;
    logic [15:0] cyl_o;

    assign o         = st_reg[NS-1];
    assign q_ext     = 32'(o.num);
    assign lba_o_ext = 32'(o.lba);
    assign cyl_o     = (q_ext > 32'hFFFF) ? 16'hFFFF : q_ext[15:0];

    assign m_tvalid = vld_reg[NS-1];
    assign m_tuser  = o.err;
    assign m_tdata  = (o.req == REQ_TO_LBA) ?
                      {o.sect, o.head, o.cyl, o.prod[23:0]} :
                      {o.rem1, o.rem2, cyl_o, lba_o_ext[23:0]};

`include "lba_chs_translator_core_defines.svh"

    `LCT_ASSERT_NOW(a_full_when_blocked, !s_tready, m_tvalid && !m_tready)
    `LCT_ASSERT_NOW(a_chs_sect_in_range, m_tvalid && o.req == REQ_TO_CHS, o.rem1 < spt_nz)
    `LCT_ASSERT_NOW(a_chs_head_in_range, m_tvalid && o.req == REQ_TO_CHS, o.rem2 < hpc_nz)
    `LCT_ASSERT_NXT(a_stall_keeps_output, m_tvalid && !m_tready, m_tvalid)

endmodule

/* verif/tb_lba_chs_translator_core.sv */
`timescale 1ns / 100ps
// Testbench for lba_chs_translator_core: directed table then random requests,
// checked word by word against an in-bench translation model. Depends on lct_pkg.
module tb_lba_chs_translator_core;
    import lct_pkg::*;

    localparam int LATENCY = 2 * 24 + 1;
    localparam int LIMIT   = 400000;
    localparam logic [23:0] LBA_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic        req;
        logic [23:0] lba;
        logic [7:0]  cnt;
        logic [15:0] cyl;
        logic [7:0]  head;
        logic [7:0]  sect;
    } xlat_req_t;

    typedef struct packed {
        logic [23:0] lba;
        logic [15:0] cyl;
        logic [7:0]  head;
        logic [7:0]  sect;
        logic        err;
    } xlat_res_t;

    typedef struct {
        xlat_req_t rq;
        logic      known;
        xlat_res_t res;
    } dir_row_t;

    logic clk, rst_n;
    logic s_tvalid, s_tready, s_tuser;
    logic [IN_DATA_W-1:0] s_tdata;
    logic m_tvalid, m_tready, m_tuser;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic cfg_valid, cfg_ready;
    logic [1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [7:0]  geo_heads, geo_spt;
    logic [15:0] geo_cyls;
    logic [23:0] geo_total;

    xlat_res_t expected_q[$];
    int  fails = 0, cycles = 0, n_words = 0, n_err = 0;
    bit  hold_off = 1'b0;

    lba_chs_translator_core i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic xlat_res_t translate(xlat_req_t rq);
        xlat_res_t r;
        logic [63:0] hpc, spt, q, l;
        hpc = (geo_heads == 0) ? 64'd1 : 64'(geo_heads);
        spt = (geo_spt == 0) ? 64'd1 : 64'(geo_spt);
        if (rq.req == REQ_TO_CHS)
        begin
            q = 64'(rq.lba) / (hpc * spt);
            r.lba  = rq.lba;
            r.cyl  = (q > 64'hFFFF) ? 16'hFFFF : q[15:0];
            r.head = 8'((64'(rq.lba) / spt) % hpc);
            r.sect = 8'(64'(rq.lba) % spt);
            r.err  = (64'(rq.lba) + 64'(rq.cnt)) > 64'(geo_total);
        end
        else
        begin
            l = (64'(rq.cyl) * hpc + 64'(rq.head)) * spt + 64'(rq.sect);
            r.err = (l > 64'(LBA_MAX)) || rq.cyl >= geo_cyls ||
                    rq.head >= geo_heads || rq.sect >= geo_spt;
            r.lba  = (l > 64'(LBA_MAX)) ? LBA_MAX : l[23:0];
            r.cyl  = rq.cyl;
            r.head = rq.head;
            r.sect = rq.sect;
        end
        return r;
    endfunction

    // receiver: own stall pattern plus a long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                m_tready <= 1'b0;
            else
                case (cycles % 97 < 40 ? 0 : $urandom_range(0, 2))
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    default: m_tready <= ($urandom_range(0, 3) == 0);
                endcase
        end
    end

    // result checker
    always @(posedge clk)
    begin
        xlat_res_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result word with nothing expected");
                fails++;
            end
            else
            begin
                e = expected_q.pop_front();
                n_words++;
                if (e.err) n_err++;
                if (m_tdata[23:0] !== e.lba)
                begin $error("lba_out exp %0d got %0d", e.lba, m_tdata[23:0]); fails++; end
                if (m_tdata[39:24] !== e.cyl)
                begin $error("cyl_out exp %0d got %0d", e.cyl, m_tdata[39:24]); fails++; end
                if (m_tdata[47:40] !== e.head)
                begin $error("head_out exp %0d got %0d", e.head, m_tdata[47:40]); fails++; end
                if (m_tdata[55:48] !== e.sect)
                begin $error("sect_out exp %0d got %0d", e.sect, m_tdata[55:48]); fails++; end
                if (m_tuser !== e.err)
                begin $error("range_error exp %0b got %0b", e.err, m_tuser); fails++; end
            end
        end
    end

    // one register write, then the config channel goes quiet
    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_HEADS:   geo_heads = val[7:0];
            CFG_SECTORS: geo_spt   = val[7:0];
            CFG_CYLS:    geo_cyls  = val[15:0];
            default:     geo_total = val;
        endcase
        @(posedge clk);
    endtask

    task automatic drain;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    // one word on the slave side; valid stays high between back-to-back words
    task automatic send_req(input xlat_req_t rq, input logic known, input xlat_res_t res);
        s_tvalid <= 1'b1;
        s_tuser  <= rq.req;
        s_tdata  <= {rq.sect, rq.head, rq.cyl, rq.cnt, rq.lba};
        do @(posedge clk); while (!s_tready);
        expected_q.push_back(known ? res : translate(rq));
    endtask

    task automatic idle(input int n);
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    function automatic xlat_req_t rand_req(input int mode);
        xlat_req_t rq;
        logic [7:0] h, s;
        h = (geo_heads == 0) ? 8'd1 : geo_heads;
        s = (geo_spt == 0) ? 8'd1 : geo_spt;
        rq = xlat_req_t'({$urandom, $urandom, $urandom});
        if (mode == 0)
        begin
            if (rq.req == REQ_TO_CHS)
            begin
                if ($urandom_range(0, 1))
                    rq.lba = 24'($urandom_range(0, geo_total));
            end
            else
            begin
                rq.cyl  = 16'($urandom_range(0, (geo_cyls == 0) ? 0 : geo_cyls - 1));
                rq.head = 8'($urandom_range(0, h - 1));
                rq.sect = 8'($urandom_range(0, s - 1));
                if ($urandom_range(0, 2) == 0) rq.cyl = 16'($urandom_range(0, 3));
            end
        end
        return rq;
    endfunction

    dir_row_t dir_rows[$];

    function automatic dir_row_t row(logic known, logic rt, logic [23:0] lba, logic [7:0] cnt,
                                     logic [15:0] cyl, logic [7:0] hd, logic [7:0] sc,
                                     xlat_res_t res);
        dir_row_t d;
        d.rq = '{req: rt, lba: lba, cnt: cnt, cyl: cyl, head: hd, sect: sc};
        d.known = known;
        d.res = res;
        return d;
    endfunction

    initial
    begin
        xlat_req_t rq;
        int burst;
        xlat_res_t none;
        bit stalled;
        none = '0;
        stalled = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0; s_tdata = '0; s_tuser = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        geo_heads = HEADS_RST; geo_spt = SECTORS_RST;
        geo_cyls = CYLS_RST; geo_total = TOTAL_RST;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset: 16 heads, 63 sectors, 1024 cylinders
        dir_rows.push_back(row(1, REQ_TO_CHS, 24'd0, 8'd0, 16'd0, 8'd0, 8'd0,
                               '{24'd0, 16'd0, 8'd0, 8'd0, 1'b0}));
        dir_rows.push_back(row(1, REQ_TO_CHS, 24'd1032192, 8'd0, 16'd0, 8'd0, 8'd0,
                               '{24'd1032192, 16'd1024, 8'd0, 8'd0, 1'b0}));
        dir_rows.push_back(row(1, REQ_TO_CHS, 24'd1032192, 8'd1, 16'd0, 8'd0, 8'd0,
                               '{24'd1032192, 16'd1024, 8'd0, 8'd0, 1'b1}));
        dir_rows.push_back(row(1, REQ_TO_CHS, 24'd62, 8'd255, 16'hFFFF, 8'hFF, 8'hFF,
                               '{24'd62, 16'd0, 8'd0, 8'd62, 1'b0}));
        dir_rows.push_back(row(0, REQ_TO_CHS, LBA_MAX, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF, none));
        dir_rows.push_back(row(1, REQ_TO_LBA, 24'hFFFFFF, 8'hFF, 16'd0, 8'd0, 8'd0,
                               '{24'd0, 16'd0, 8'd0, 8'd0, 1'b0}));
        dir_rows.push_back(row(1, REQ_TO_LBA, 24'd0, 8'd0, 16'd1023, 8'd15, 8'd62,
                               '{24'd1032191, 16'd1023, 8'd15, 8'd62, 1'b0}));
        dir_rows.push_back(row(1, REQ_TO_LBA, 24'd0, 8'd0, 16'd1024, 8'd0, 8'd0,
                               '{24'd1032192, 16'd1024, 8'd0, 8'd0, 1'b1}));
        dir_rows.push_back(row(1, REQ_TO_LBA, 24'd0, 8'd0, 16'd0, 8'd16, 8'd0,
                               '{24'd1008, 16'd0, 8'd16, 8'd0, 1'b1}));
        dir_rows.push_back(row(1, REQ_TO_LBA, 24'd0, 8'd0, 16'd0, 8'd0, 8'd63,
                               '{24'd63, 16'd0, 8'd0, 8'd63, 1'b1}));
        // LBA saturation
        dir_rows.push_back(row(1, REQ_TO_LBA, 24'd0, 8'd0, 16'hFFFF, 8'hFF, 8'hFF,
                               '{LBA_MAX, 16'hFFFF, 8'hFF, 8'hFF, 1'b1}));
        foreach (dir_rows[i]) send_req(dir_rows[i].rq, dir_rows[i].known, dir_rows[i].res);
        idle(1);
        drain();

        // degenerate geometry: zero heads, sectors and cylinders
        write_reg(CFG_HEADS, 24'd0);
        write_reg(CFG_SECTORS, 24'd0);
        write_reg(CFG_CYLS, 24'd0);
        write_reg(CFG_TOTAL, 24'hFFFFFF);
        send_req('{REQ_TO_CHS, 24'd70000, 8'd5, 16'd0, 8'd0, 8'd0}, 1,
                 '{24'd70000, 16'hFFFF, 8'd0, 8'd0, 1'b0});
        send_req('{REQ_TO_LBA, 24'd0, 8'd0, 16'd0, 8'd0, 8'd0}, 1,
                 '{24'd0, 16'd0, 8'd0, 8'd0, 1'b1});
        send_req('{REQ_TO_CHS, LBA_MAX, 8'd1, 16'd0, 8'd0, 8'd0}, 1,
                 '{LBA_MAX, 16'hFFFF, 8'd0, 8'd0, 1'b1});
        idle(1);
        drain();

        // random phases over several geometries, extremes included
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin write_reg(CFG_HEADS, 24'd255); write_reg(CFG_SECTORS, 24'd255);
                         write_reg(CFG_CYLS, 24'hFFFF); write_reg(CFG_TOTAL, 24'd1); end
                1: begin write_reg(CFG_HEADS, 24'd1); write_reg(CFG_SECTORS, 24'd1);
                         write_reg(CFG_CYLS, 24'd1); write_reg(CFG_TOTAL, 24'hFFFFFF); end
                default: begin
                    write_reg(CFG_HEADS, 24'($urandom_range(0, 255)));
                    write_reg(CFG_SECTORS, 24'($urandom_range(0, 255)));
                    write_reg(CFG_CYLS, 24'($urandom_range(0, 65535)));
                    write_reg(CFG_TOTAL, 24'($urandom_range(1, 24'hFFFFFF)));
                end
            endcase
            for (int n = 0; n < 150; )
            begin
                if (ph == 2 && n >= 40 && !stalled)
                begin
                    stalled = 1'b1;
                    fork
                        begin
                            hold_off = 1'b1;
                            repeat (300) @(posedge clk);
                            hold_off = 1'b0;
                        end
                    join_none
                end
                burst = $urandom_range(1, 20);
                for (int k = 0; k < burst && n < 150; k++, n++)
                begin
                    rq = rand_req($urandom_range(0, 3) == 0);
                    send_req(rq, 0, none);
                end
                idle($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6));
            end
            idle(1);
            drain();
        end

        drain();
        $display("Checked %0d result words (%0d with range_error) over 8 geometries,",
                 n_words, n_err);
        $display("including zero and full-scale registers and a long output stall.");
        if (fails == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
